/* hdl/tkls_pkg.sv */
// Package with the word types, register codes and ordering functions of the top-k selector.
`default_nettype none
package tkls_pkg;
    localparam int unsigned IDX_W = 18;
    localparam int unsigned VAL_W = 32;

    typedef struct packed {
        logic [31:0] logit_bits;
        logic        last_logit;
    } in_word_t;

    typedef struct packed {
        logic [17:0] token;
        logic [31:0] value_bits;
        logic        is_finite;
        logic        last_of_run;
    } out_word_t;

    typedef struct packed {
        logic [31:0] bits;
        logic [17:0] idx;
        logic        last;
    } cand_t;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_SEND = 2'd1
    } back_state_t;

    localparam logic [0:0] REG_TOP_K = 1'b0;

    function automatic logic bits_finite(input logic [31:0] b);
        return b[30:23] != 8'hFF;
    endfunction

    function automatic logic [31:0] order_key(input logic [31:0] b);
        logic [31:0] k;
        if (b[30:0] == 31'd0) begin
            k = 32'h8000_0000;
        end else if (b[31]) begin
            k = ~b;
        end else begin
            k = b | 32'h8000_0000;
        end
        return k;
    endfunction

    function automatic logic new_beats(input logic [31:0] nb, input logic [31:0] kb);
        logic nf;
        logic kf;
        logic r;
        nf = bits_finite(nb);
        kf = bits_finite(kb);
        if (nf != kf) begin
            r = nf;
        end else if (!nf) begin
            r = 1'b0;
        end else begin
            r = order_key(nb) > order_key(kb);
        end
        return r;
    endfunction
endpackage
`default_nettype wire

/* hdl/tkls_front.sv */
// Front end: accepts logit words, numbers them and places them in a short queue.
`default_nettype none
module tkls_front
    import tkls_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = 262144,
    parameter int unsigned DEPTH     = 4
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_data,
    output logic          q_valid,
    input  wire logic     q_ready,
    output cand_t         q_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned PW = $clog2(MAX_ITEMS);

    cand_t          fifo_reg [DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [CW-1:0]  cnt_reg;
    logic [PW-1:0]  pos_reg, pos_next;
    logic           push, pop;

    assign s_ready = cnt_reg != CW'(DEPTH);
    assign q_valid = cnt_reg != '0;
    assign q_data  = fifo_reg[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        if (s_data.last_logit || pos_reg == PW'(MAX_ITEMS - 1)) begin
            pos_next = '0;
        end else begin
            pos_next = pos_reg + PW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
            pos_reg <= '0;
        end else begin
            if (push) begin
                wp_reg  <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                pos_reg <= pos_next;
            end
            if (pop) begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wp_reg].bits <= s_data.logit_bits;
            fifo_reg[wp_reg].idx  <= IDX_W'(pos_reg);
            fifo_reg[wp_reg].last <= s_data.last_logit;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= CW'(DEPTH))
        else $error("queue count above depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && s_data.last_logit) |=> pos_reg == '0)
        else $error("position not cleared after last word");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> !q_valid)
        else $error("empty queue shows valid");
endmodule
`default_nettype wire

/* hdl/tkls_back.sv */
// Back end: shift-insert list of the best candidates and the result drain.
`default_nettype none
module tkls_back
    import tkls_pkg::*;
#(
    parameter int unsigned MAX_K = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [6:0] top_k,
    input  wire logic       q_valid,
    output logic            q_ready,
    input  wire cand_t      q_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_word_t       m_data
);
    localparam int unsigned KW = $clog2(MAX_K + 1);

    logic [31:0]   val_reg [MAX_K];
    logic [17:0]   idx_reg [MAX_K];
    logic [KW-1:0] fill_reg, fill_next;
    logic [KW-1:0] left_reg, left_next;
    back_state_t   state_reg, state_next;
    logic [KW-1:0] k_eff, fill_cut;
    logic [MAX_K-1:0] beat, ins;
    logic          take, shift_out;
    logic          ovalid_reg;
    out_word_t     odata_reg;
    logic          oload;

    always_comb begin
        if (top_k == 7'd0) begin
            k_eff = KW'(1);
        end else if ({25'd0, top_k} > MAX_K) begin
            k_eff = KW'(MAX_K);
        end else begin
            k_eff = KW'(top_k);
        end
        fill_cut = (fill_reg > k_eff) ? k_eff : fill_reg;
    end

    assign q_ready = state_reg == ST_RUN;
    assign take    = q_valid && q_ready;

    always_comb begin
        for (int i = 0; i < MAX_K; i++) begin
            beat[i] = (KW'(i) >= fill_cut) || new_beats(q_data.bits, val_reg[i]);
            ins[i]  = (KW'(i) < k_eff) && beat[i];
        end
    end

    assign oload     = !ovalid_reg || m_ready;
    assign shift_out = (state_reg == ST_SEND) && oload && left_reg != '0;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN: begin
                if (take && q_data.last) begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                if (left_reg == '0 || (shift_out && left_reg == KW'(1))) begin
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_comb begin
        fill_next = fill_reg;
        left_next = left_reg;
        case (state_reg)
            ST_RUN: begin
                if (take) begin
                    fill_next = (ins[0] || |ins) && fill_cut < k_eff ?
                        fill_cut + KW'(1) : fill_cut;
                    if (q_data.last) begin
                        left_next = fill_next;
                        fill_next = '0;
                    end
                end
            end
            ST_SEND: begin
                if (shift_out) begin
                    left_next = left_reg - KW'(1);
                end
            end
            default: begin
                fill_next = '0;
                left_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_RUN;
            fill_reg   <= '0;
            left_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            left_reg  <= left_next;
            if (shift_out) begin
                ovalid_reg <= 1'b1;
            end else if (m_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            for (int i = 0; i < MAX_K; i++) begin
                if (ins[i]) begin
                    if (i == 0 || !beat[(i == 0) ? 0 : i - 1]) begin
                        val_reg[i] <= q_data.bits;
                        idx_reg[i] <= q_data.idx;
                    end else begin
                        val_reg[i] <= val_reg[(i == 0) ? 0 : i - 1];
                        idx_reg[i] <= idx_reg[(i == 0) ? 0 : i - 1];
                    end
                end
            end
        end else if (shift_out) begin
            for (int i = 0; i < MAX_K - 1; i++) begin
                val_reg[i] <= val_reg[i + 1];
                idx_reg[i] <= idx_reg[i + 1];
            end
        end
        if (shift_out) begin
            odata_reg.token       <= idx_reg[0];
            odata_reg.value_bits  <= val_reg[0];
            odata_reg.is_finite   <= bits_finite(val_reg[0]);
            odata_reg.last_of_run <= left_reg == KW'(1);
        end
    end

    assign m_valid = ovalid_reg;
    assign m_data  = odata_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) fill_reg <= KW'(MAX_K))
        else $error("fill count above list size");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEND) |-> !q_ready)
        else $error("input taken while draining");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data))
        else $error("stalled result changed");
endmodule
`default_nettype wire

/* hdl/top_k_logit_selector_unit.sv */
// Top level of the streaming top-k logit selector with its APB register.
//  channel | direction | word
//  s_      | in        | in_word_t: logit_bits, last_logit
//  m_      | out       | out_word_t: token, value_bits, is_finite, last_of_run
//  apb     | in/out    | top_k at address 0
// A logit word is taken each cycle while the four-word queue has room; the list insert is registered.
// After the last word the list drains min(top_k, count) results (top_k held to 1..MAX_K), one a
// cycle unless the output stalls; no new word enters the list meanwhile, but the queue takes input.
// Reset is synchronous and clears counts, queue and state; top_k returns to 1.
`default_nettype none
module top_k_logit_selector_unit
    import tkls_pkg::*;
#(
    parameter int unsigned MAX_K     = 64,
    parameter int unsigned MAX_ITEMS = 262144
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_word_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_word_t        m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [6:0] top_k_reg;
    logic       q_valid, q_ready;
    cand_t      q_data;

    assign pready = 1'b1;
    assign prdata = (paddr[1:0] == 2'd0 && REG_TOP_K == 1'b0) ? {25'd0, top_k_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_k_reg <= 7'd1;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            top_k_reg <= pwdata[6:0];
        end
    end

    tkls_front #(.MAX_ITEMS(MAX_ITEMS), .DEPTH(4)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    tkls_back #(.MAX_K(MAX_K)) u_back (
        .aclk(aclk), .aresetn(aresetn), .top_k(top_k_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule
`default_nettype wire

/* dv/tkls_checker.sv */
// Checker that predicts the top-k selector's result words and compares them field by field.
`timescale 1ns / 1ps
module tkls_checker
    import tkls_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire in_word_t  s_data,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire out_word_t m_data,
    input  wire logic      cfg_we,
    input  wire logic [6:0] cfg_k,
    output int             fail_count,
    output int             pending
);
    logic [31:0] list_bits [64];
    logic [17:0] list_idx [64];
    int unsigned list_len;
    logic [17:0] pos;
    logic [6:0] k_reg;
    out_word_t expected_words[$];

    assign pending = expected_words.size();

    function automatic logic finite_bits(input logic [31:0] b);
        return b[30:23] != 8'hFF;
    endfunction

    function automatic logic [31:0] rank_key(input logic [31:0] b);
        if (b[30:0] == 31'd0) return 32'h8000_0000;
        if (b[31]) return ~b;
        return b | 32'h8000_0000;
    endfunction

    function automatic logic outranks(input logic [31:0] nb, input logic [31:0] kb);
        if (finite_bits(nb) != finite_bits(kb)) return finite_bits(nb);
        if (!finite_bits(nb)) return 1'b0;
        return rank_key(nb) > rank_key(kb);
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        fail_count++;
    endtask

    task automatic insert_logit(input in_word_t w);
        int unsigned k;
        int unsigned i;
        int unsigned j;
        out_word_t o;
        k = (k_reg == 0) ? 1 : ((k_reg > 64) ? 64 : k_reg);
        if (list_len > k) list_len = k;
        i = 0;
        while (i < list_len && !outranks(w.logit_bits, list_bits[i])) i++;
        if (i < k) begin
            j = (list_len < k) ? list_len : k - 1;
            while (j > i) begin
                list_bits[j] = list_bits[j-1];
                list_idx[j] = list_idx[j-1];
                j--;
            end
            list_bits[i] = w.logit_bits;
            list_idx[i] = pos;
            if (list_len < k) list_len++;
        end
        pos = pos + 1'b1;
        if (w.last_logit) begin
            for (i = 0; i < list_len; i++) begin
                o.token = list_idx[i];
                o.value_bits = list_bits[i];
                o.is_finite = finite_bits(list_bits[i]);
                o.last_of_run = (i + 1 == list_len);
                expected_words = {expected_words, o};
            end
            list_len = 0;
            pos = '0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            list_len = 0;
            pos = '0;
            k_reg = 7'd1;
            fail_count = 0;
            expected_words.delete();
        end else begin
            if (cfg_we) k_reg = cfg_k;
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    report("unexpected word", 64'(m_data.value_bits), 64'(0));
                end else begin
                    out_word_t e;
                    e = expected_words.pop_front();
                    if (m_data.token !== e.token)
                        report("token", 64'(m_data.token), 64'(e.token));
                    if (m_data.value_bits !== e.value_bits)
                        report("value_bits", 64'(m_data.value_bits), 64'(e.value_bits));
                    if (m_data.is_finite !== e.is_finite)
                        report("is_finite", 64'(m_data.is_finite), 64'(e.is_finite));
                    if (m_data.last_of_run !== e.last_of_run)
                        report("last_of_run", 64'(m_data.last_of_run), 64'(e.last_of_run));
                end
            end
            if (s_valid && s_ready) insert_logit(s_data);
        end
    end
endmodule

/* dv/tb_top.sv */
// Testbench top that drives logit vectors and register writes into the top-k selector.
`timescale 1ns / 1ps
module tb_top;
    import tkls_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    int fail_count;
    int pending;
    int idle_cycles = 0;
    int burst_left = 0;
    int stall_phase = 0;
    logic stall_on = 1'b0;

    localparam int IDLE_LIMIT = 20000;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    top_k_logit_selector_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tkls_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(psel && penable && pwrite && pready && paddr == {1'b0, REG_TOP_K}),
        .cfg_k(pwdata[6:0]),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 64 < 16) m_ready <= 1'b1;
        else if (stall_phase % 64 < 40) m_ready <= ($urandom_range(0, 3) != 0);
        else m_ready <= ($urandom_range(0, 1) != 0) && !stall_on;
        if (stall_phase % 97 == 0) stall_on <= ($urandom_range(0, 3) == 0);
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_top_k(input logic [6:0] k);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {1'b0, REG_TOP_K}; pwdata <= {25'd0, k};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_logit(input logic [31:0] bits, input logic last, input bit gaps);
        int gap;
        if (gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(0, 5);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
        end
        s_valid <= 1'b1;
        s_data <= '{logit_bits: bits, last_logit: last};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_logit();
        case ($urandom_range(0, 9))
            0: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom)};
            1: return {$urandom_range(0, 1) == 1, 31'd0};
            2: return {$urandom_range(0, 1) == 1, 8'd127, 23'($urandom_range(0, 3))};
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] directed [14];
        int n;
        directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0001, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001,
                     32'h8000_0001, 32'h3F80_0000, 32'h3F80_0000, 32'hFFFF_FFFF,
                     32'hBF80_0000, 32'h7F7F_FFFF};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < 14; i++) send_logit(directed[i], i == 13, 1'b0);
        drain();
        write_top_k(7'd64);
        for (int i = 0; i < 14; i++) send_logit(directed[i], i == 13, 1'b0);
        send_logit(32'hFFFF_FFFF, 1'b1, 1'b0);
        drain();
        write_top_k(7'd0);
        send_logit(32'h4000_0000, 1'b0, 1'b0);
        send_logit(32'h4040_0000, 1'b1, 1'b0);
        drain();
        write_top_k(7'd127);
        for (int i = 0; i < 3; i++) send_logit(rand_logit(), i == 2, 1'b0);
        drain();
        n = 0;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_top_k(7'd1);
                1: write_top_k(7'd64);
                2: write_top_k(7'd3);
                3: write_top_k(7'($urandom_range(65, 127)));
                default: write_top_k(7'($urandom_range(1, 16)));
            endcase
            while (n < 70 * (phase + 1)) begin
                int len;
                len = $urandom_range(1, 20);
                for (int i = 0; i < len; i++) begin
                    send_logit(rand_logit(), i == len - 1, 1'b1);
                    n++;
                end
            end
            drain();
        end
        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
